/* hdl/ffca_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types, status codes and default sizes for the first-fit allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int FIELD_W = 20;

  localparam int FREE_SLOTS_DEF         = 64;
  localparam int USED_SLOTS_DEF         = 64;
  localparam int ADDR_BITS_DEF          = 20;
  localparam int HEADER_BYTES_DEF       = 16;
  localparam int ALIGN_BYTES_DEF        = 16;
  localparam int ARENA_HEADER_BYTES_DEF = 32;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] data_address;
  } out_word_t;

endpackage
`default_nettype wire

/* hdl/ffca_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/ffca_align.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_align
// Rounds a request up to the alignment: reciprocal multiply, one correction.
// ----------------------------------------------------------------------------
module ffca_align #(
  parameter int ALIGN_BYTES = ffca_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic [ffca_pkg::FIELD_W-1:0] req,
  output logic      [ffca_pkg::FIELD_W+1:0] need
);

  localparam int          SH    = 28;
  localparam logic [28:0] RECIP = 29'((64'd1 << SH) / ALIGN_BYTES);

  logic [20:0] x;
  logic [20:0] x_r;
  logic [49:0] prod_r;
  logic [21:0] q0;
  logic [27:0] q0a;
  logic [27:0] rem;
  logic [27:0] rnd;

  assign x = {1'b0, req} + 21'(ALIGN_BYTES - 1);

  always_ff @(posedge clk) begin
    x_r    <= x;
    prod_r <= {29'd0, x} * {21'd0, RECIP};
  end

  // quotient estimate is low by at most one
  assign q0   = prod_r[49:SH];
  assign q0a  = 28'(q0) * 28'(ALIGN_BYTES);
  assign rem  = 28'(x_r) - q0a;
  assign rnd  = (rem >= 28'(ALIGN_BYTES)) ? q0a + 28'(ALIGN_BYTES) : q0a;
  assign need = rnd[21:0];

endmodule
`default_nettype wire

/* hdl/first_fit_coalescing_allocator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_core
// First-fit arena allocator with an address-sorted, coalescing free table.
// ----------------------------------------------------------------------------
//  channel | ports                         | word
//  --------+-------------------------------+-------------------------------
//  input   | in_valid  in_stall  in_word   | action, request_size, free_address
//  result  | out_valid out_stall out_word  | status, data_address
//  config  | cfg_we    cfg_wdata           | arena bytes
//
//  One word at a time. The sequencer walks the free table (and for a free the
//  used table) through one-read, one-write RAMs, an entry at a time: read,
//  then compare. Inserts and removals shift entries the same way. Reset is
//  synchronous and leaves the free table empty. A stalled result sits in the
//  output register; the next word is taken meanwhile and its result waits
//  until that register is free.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_core #(
  parameter int FREE_SLOTS         = ffca_pkg::FREE_SLOTS_DEF,
  parameter int USED_SLOTS         = ffca_pkg::USED_SLOTS_DEF,
  parameter int ADDR_BITS          = ffca_pkg::ADDR_BITS_DEF,
  parameter int HEADER_BYTES       = ffca_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES        = ffca_pkg::ALIGN_BYTES_DEF,
  parameter int ARENA_HEADER_BYTES = ffca_pkg::ARENA_HEADER_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire ffca_pkg::in_word_t           in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ffca_pkg::out_word_t               out_word,
  input  wire logic                         cfg_we,
  input  wire logic [ffca_pkg::FIELD_W-1:0] cfg_wdata
);

  localparam int FW    = ffca_pkg::FIELD_W;
  localparam int AB    = ADDR_BITS;
  localparam int WW    = ((AB > FW) ? AB : FW) + 2;   // arithmetic width
  localparam int FA_W  = $clog2(FREE_SLOTS);
  localparam int FC_W  = $clog2(FREE_SLOTS + 1);
  localparam int UA_W  = $clog2(USED_SLOTS);
  localparam int UI_W  = UA_W + 1;

  localparam logic [WW-1:0] HW      = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] AHW     = WW'(ARENA_HEADER_BYTES);
  localparam logic [WW-1:0] ADDR_MX = WW'((64'd1 << AB) - 64'd1);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_ALN  = 15'h0002,
    S_NEED = 15'h0004,
    S_ARD  = 15'h0008,
    S_AEV  = 15'h0010,
    S_DRD  = 15'h0020,
    S_DWR  = 15'h0040,
    S_URD  = 15'h0080,
    S_UEV  = 15'h0100,
    S_FRD  = 15'h0200,
    S_FEV  = 15'h0400,
    S_FMG  = 15'h0800,
    S_IRD  = 15'h1000,
    S_IWR  = 15'h2000,
    S_DONE = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [FC_W-1:0]       cnt_r, cnt_nxt;
  logic [USED_SLOTS-1:0] uval_r, uval_nxt;
  logic [FC_W-1:0]       idx_r, idx_nxt;
  logic [FC_W-1:0]       k_r, k_nxt;
  logic [UI_W-1:0]       uidx_r, uidx_nxt;
  logic [FW-1:0]         req_r, req_nxt;
  logic [FW-1:0]         faddr_r, faddr_nxt;
  logic [WW-1:0]         need_r, need_nxt;
  logic [AB-1:0]         bstart_r, bstart_nxt;
  logic [AB-1:0]         bsize_r, bsize_nxt;
  logic [UA_W-1:0]       uslot_r, uslot_nxt;
  logic [AB-1:0]         pstart_r, pstart_nxt;
  logic [AB-1:0]         psize_r, psize_nxt;
  logic                  hprev_r, hprev_nxt;
  logic [AB-1:0]         cstart_r, cstart_nxt;
  logic [AB-1:0]         csize_r, csize_nxt;
  logic                  hcur_r, hcur_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [FW-1:0]         daddr_r, daddr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ffca_pkg::out_word_t   out_word_r, out_word_nxt;

  // free table RAM: {start, size}
  logic            fr_we;
  logic [FA_W-1:0] fr_waddr, fr_raddr;
  logic [2*AB-1:0] fr_wdata, fr_rdata;
  // used table RAM: {start, size}
  logic            ur_we;
  logic [UA_W-1:0] ur_waddr, ur_raddr;
  logic [2*AB-1:0] ur_wdata, ur_rdata;

  logic [FW+1:0]   need_al;
  logic [AB-1:0]   rd_start, rd_size, ru_start, ru_size;
  logic [UA_W-1:0] ufirst;
  logic            uhas;
  logic [WW-1:0]   cfg_ext, eff;

  ffca_ram #(.WIDTH(2*AB), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  ffca_ram #(.WIDTH(2*AB), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk(clk), .we(ur_we), .waddr(ur_waddr), .wdata(ur_wdata),
    .raddr(ur_raddr), .rdata(ur_rdata)
  );

  ffca_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
    .clk(clk), .req(req_r), .need(need_al)
  );

  assign rd_start = fr_rdata[2*AB-1:AB];
  assign rd_size  = fr_rdata[AB-1:0];
  assign ru_start = ur_rdata[2*AB-1:AB];
  assign ru_size  = ur_rdata[AB-1:0];

  // lowest clear used slot
  always_comb begin
    ufirst = '0;
    uhas   = 1'b0;
    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
      if (!uval_r[i]) begin
        ufirst = UA_W'(i);
        uhas   = 1'b1;
      end
    end
  end

  assign cfg_ext = WW'(cfg_wdata);
  assign eff     = (cfg_ext > ADDR_MX) ? ADDR_MX : cfg_ext;

  always_comb begin
    logic [WW-1:0] csz, left, bend, pend, msum;
    logic          lm, rm;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    uval_nxt      = uval_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    uidx_nxt      = uidx_r;
    req_nxt       = req_r;
    faddr_nxt     = faddr_r;
    need_nxt      = need_r;
    bstart_nxt    = bstart_r;
    bsize_nxt     = bsize_r;
    uslot_nxt     = uslot_r;
    pstart_nxt    = pstart_r;
    psize_nxt     = psize_r;
    hprev_nxt     = hprev_r;
    cstart_nxt    = cstart_r;
    csize_nxt     = csize_r;
    hcur_nxt      = hcur_r;
    status_nxt    = status_r;
    daddr_nxt     = daddr_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = '0;
    fr_raddr = idx_r[FA_W-1:0];
    ur_we    = 1'b0;
    ur_waddr = '0;
    ur_wdata = '0;
    ur_raddr = uidx_r[UA_W-1:0];

    csz  = WW'(rd_size);
    left = csz - need_r;
    bend = WW'(bstart_r) + HW + WW'(bsize_r);
    pend = WW'(pstart_r) + HW + WW'(psize_r);
    lm   = hprev_r && (pend == WW'(bstart_r));
    rm   = hcur_r && (WW'(cstart_r) == bend);
    msum = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_word.request_size;
          faddr_nxt  = in_word.free_address;
          status_nxt = ffca_pkg::ST_OK;
          daddr_nxt  = '0;
          idx_nxt    = '0;
          uidx_nxt   = '0;
          hprev_nxt  = 1'b0;
          hcur_nxt   = 1'b0;
          state_nxt  = (in_word.action == ffca_pkg::ACT_FREE) ? S_URD : S_ALN;
        end
      end
      S_ALN: state_nxt = S_NEED;
      S_NEED: begin
        need_nxt  = WW'(need_al);
        state_nxt = S_ARD;
      end
      // first-fit scan
      S_ARD: begin
        if (idx_r >= cnt_r) begin
          status_nxt = ffca_pkg::ST_NOFIT;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_AEV;
        end
      end
      S_AEV: begin
        if (csz >= need_r + HW) begin
          if (!uhas) begin
            status_nxt = ffca_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            ur_we            = 1'b1;
            ur_waddr         = ufirst;
            uval_nxt[ufirst] = 1'b1;
            daddr_nxt        = FW'(WW'(rd_start) + HW);
            if (left > HW) begin
              ur_wdata  = {rd_start, AB'(need_r)};
              fr_we     = 1'b1;
              fr_waddr  = idx_r[FA_W-1:0];
              fr_wdata  = {AB'(WW'(rd_start) + HW + need_r), AB'(left - HW)};
              state_nxt = S_DONE;
            end else begin
              ur_wdata  = {rd_start, rd_size};
              k_nxt     = idx_r;
              state_nxt = S_DRD;
            end
          end
        end else begin
          idx_nxt   = idx_r + FC_W'(1);
          state_nxt = S_ARD;
        end
      end
      // remove entry k, pulling later ones down
      S_DRD: begin
        fr_raddr = FA_W'(k_r + FC_W'(1));
        if ((k_r + FC_W'(1)) < cnt_r) begin
          state_nxt = S_DWR;
        end else begin
          cnt_nxt   = cnt_r - FC_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DWR: begin
        fr_we     = 1'b1;
        fr_waddr  = k_r[FA_W-1:0];
        fr_wdata  = fr_rdata;
        k_nxt     = k_r + FC_W'(1);
        state_nxt = S_DRD;
      end
      // used table lookup
      S_URD: begin
        if (uidx_r == UI_W'(USED_SLOTS)) begin
          status_nxt = ffca_pkg::ST_BADADDR;
          state_nxt  = S_DONE;
        end else if (!uval_r[uidx_r[UA_W-1:0]]) begin
          uidx_nxt = uidx_r + UI_W'(1);
        end else begin
          state_nxt = S_UEV;
        end
      end
      S_UEV: begin
        if (WW'(ru_start) + HW == WW'(faddr_r)) begin
          bstart_nxt = ru_start;
          bsize_nxt  = ru_size;
          uslot_nxt  = uidx_r[UA_W-1:0];
          state_nxt  = S_FRD;
        end else begin
          uidx_nxt  = uidx_r + UI_W'(1);
          state_nxt = S_URD;
        end
      end
      // find sorted place
      S_FRD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_FEV;
        end else begin
          state_nxt = S_FMG;
        end
      end
      S_FEV: begin
        if (rd_start < bstart_r) begin
          pstart_nxt = rd_start;
          psize_nxt  = rd_size;
          hprev_nxt  = 1'b1;
          idx_nxt    = idx_r + FC_W'(1);
          state_nxt  = S_FRD;
        end else begin
          cstart_nxt = rd_start;
          csize_nxt  = rd_size;
          hcur_nxt   = 1'b1;
          state_nxt  = S_FMG;
        end
      end
      S_FMG: begin
        if (lm) begin
          msum = WW'(psize_r) + HW + WW'(bsize_r);
          if (rm) begin
            msum = msum + HW + WW'(csize_r);
          end
          fr_we    = 1'b1;
          fr_waddr = FA_W'(idx_r - FC_W'(1));
          fr_wdata = {pstart_r, AB'(msum)};
          uval_nxt[uslot_r] = 1'b0;
          if (rm) begin
            k_nxt     = idx_r;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (rm) begin
          fr_we    = 1'b1;
          fr_waddr = idx_r[FA_W-1:0];
          fr_wdata = {bstart_r, AB'(WW'(bsize_r) + HW + WW'(csize_r))};
          uval_nxt[uslot_r] = 1'b0;
          state_nxt = S_DONE;
        end else if (cnt_r == FC_W'(FREE_SLOTS)) begin
          status_nxt = ffca_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = cnt_r;
          state_nxt = S_IRD;
        end
      end
      // open a gap at idx, pushing entries up
      S_IRD: begin
        fr_raddr = FA_W'(k_r - FC_W'(1));
        if (k_r > idx_r) begin
          state_nxt = S_IWR;
        end else begin
          fr_we    = 1'b1;
          fr_waddr = idx_r[FA_W-1:0];
          fr_wdata = {bstart_r, bsize_r};
          cnt_nxt  = cnt_r + FC_W'(1);
          uval_nxt[uslot_r] = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_IWR: begin
        fr_we     = 1'b1;
        fr_waddr  = k_r[FA_W-1:0];
        fr_wdata  = fr_rdata;
        k_nxt     = k_r - FC_W'(1);
        state_nxt = S_IRD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = status_r;
          out_word_nxt.data_address =
            (status_r == ffca_pkg::ST_OK) ? daddr_r : '0;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // arena rebuild; to be written only while idle, a rule the user keeps and the core leaves unchecked
    if (cfg_we) begin
      uval_nxt = '0;
      if (eff >= AHW + HW) begin
        cnt_nxt  = FC_W'(1);
        fr_we    = 1'b1;
        fr_waddr = '0;
        fr_wdata = {AB'(AHW), AB'(eff - AHW - HW)};
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      uval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      uval_r      <= uval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    uidx_r     <= uidx_nxt;
    req_r      <= req_nxt;
    faddr_r    <= faddr_nxt;
    need_r     <= need_nxt;
    bstart_r   <= bstart_nxt;
    bsize_r    <= bsize_nxt;
    uslot_r    <= uslot_nxt;
    pstart_r   <= pstart_nxt;
    psize_r    <= psize_nxt;
    hprev_r    <= hprev_nxt;
    cstart_r   <= cstart_nxt;
    csize_r    <= csize_nxt;
    hcur_r     <= hcur_nxt;
    status_r   <= status_nxt;
    daddr_r    <= daddr_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
